/* src/lfs_pkg.sv */
// Shared types and constants for the Laplacian flux stencil unit.
// No dependencies; imported by lfs_line_buffer and laplacian_flux_stencil_unit.
`default_nettype none

package lfs_pkg;

  localparam int LFS_ROW_LENGTH = 256;
  localparam int LFS_DATA_W     = 32;

  // Input word: one grid sample plus frame marker.
  typedef struct packed {
    logic signed [LFS_DATA_W-1:0] sample;
    logic                         frame_start;
  } lfs_in_t;

  // Output word: four Laplacian fluxes.
  typedef struct packed {
    logic signed [LFS_DATA_W-1:0] flux_west;
    logic signed [LFS_DATA_W-1:0] flux_east;
    logic signed [LFS_DATA_W-1:0] flux_north;
    logic signed [LFS_DATA_W-1:0] flux_south;
  } lfs_out_t;

  // Per-stage control: slot occupied, and whether it yields a result.
  typedef struct packed {
    logic valid;
    logic emit;
  } lfs_ctl_t;

  // Taps of a stream, by age relative to the word leaving the line buffer.
  typedef struct packed {
    logic signed [LFS_DATA_W-1:0] age0;
    logic signed [LFS_DATA_W-1:0] age_rm1;
    logic signed [LFS_DATA_W-1:0] age_r;
    logic signed [LFS_DATA_W-1:0] age_rp1;
    logic signed [LFS_DATA_W-1:0] age_2r;
  } lfs_taps_t;

endpackage

`default_nettype wire

/* src/lfs_line_buffer.sv */
// Two-stage line buffer: taps a word stream at ages 0, R-1, R, R+1 and 2R.
// Two chained single-port-read RAMs of R-1 words; depends on lfs_pkg.
`default_nettype none

module lfs_line_buffer
  import lfs_pkg::*;
#(
  parameter int ROW_LENGTH = LFS_ROW_LENGTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire lfs_ctl_t                     in_ctl,
  input  wire logic signed [LFS_DATA_W-1:0] in_data,
  output lfs_ctl_t                          out_ctl,
  output lfs_taps_t                         out_taps
);

  localparam int DEPTH = ROW_LENGTH - 1;
  localparam int PW    = $clog2(DEPTH);

  logic [LFS_DATA_W-1:0] mem_a [DEPTH];
  logic [LFS_DATA_W-1:0] mem_b [DEPTH];

  logic [PW-1:0] ptr_a;
  logic [PW-1:0] ptr_b;

  lfs_ctl_t                     b_ctl;
  logic signed [LFS_DATA_W-1:0] b_cur;
  logic signed [LFS_DATA_W-1:0] b_rm1;
  logic signed [LFS_DATA_W-1:0] h1;
  logic signed [LFS_DATA_W-1:0] h2;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_a   <= '0;
      ptr_b   <= '0;
      b_ctl   <= '0;
      out_ctl <= '0;
    end else if (en) begin
      b_ctl   <= in_ctl;
      out_ctl <= b_ctl;
      if (in_ctl.valid) begin
        ptr_a <= (ptr_a == PW'(DEPTH - 1)) ? '0 : ptr_a + PW'(1);
      end
      if (b_ctl.valid) begin
        ptr_b <= (ptr_b == PW'(DEPTH - 1)) ? '0 : ptr_b + PW'(1);
      end
    end
  end

  // RAMs are read-first: the entry read is the one written DEPTH words ago.
  always_ff @(posedge clk) begin
    if (en && in_ctl.valid) begin
      b_rm1        <= mem_a[ptr_a];
      mem_a[ptr_a] <= in_data;
      b_cur        <= in_data;
    end
    if (en && b_ctl.valid) begin
      out_taps.age_2r  <= mem_b[ptr_b];
      mem_b[ptr_b]     <= h2;
      h1               <= b_rm1;
      h2               <= h1;
      out_taps.age0    <= b_cur;
      out_taps.age_rm1 <= b_rm1;
      out_taps.age_r   <= h1;
      out_taps.age_rp1 <= h2;
    end
  end

endmodule

`default_nettype wire

/* src/laplacian_flux_stencil_unit.sv */
// Laplacian flux stencil unit: one sample word per cycle, sustained while the skid entry is free.
// Path of a result: sample line, Laplacian add stages, Laplacian line, flux register, output register.
// The first result of a frame follows its 4*ROW_LENGTH+3-th sample.
// A two-entry output stage lets one more word in while a result is stalled.
// Synchronous reset clears fill count, pointers and valid flags; the line
// buffer RAMs are not cleared. Depends on lfs_pkg and lfs_line_buffer.
`default_nettype none

module laplacian_flux_stencil_unit
  import lfs_pkg::*;
#(
  parameter int ROW_LENGTH = LFS_ROW_LENGTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     sample_valid,
  output logic          sample_ready,
  input  wire lfs_in_t  sample_data,
  output logic          result_valid,
  input  wire logic     result_ready,
  output lfs_out_t      result_data
);

  localparam int WIN_DEPTH = 4 * ROW_LENGTH + 3;
  localparam int FCW       = $clog2(WIN_DEPTH + 1);
  localparam int SW        = LFS_DATA_W + 4;

  function automatic logic signed [SW-1:0] ext(input logic signed [LFS_DATA_W-1:0] v);
    return {{(SW - LFS_DATA_W){v[LFS_DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [LFS_DATA_W-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-LFS_DATA_W:0] top;
    top = v[SW-1:LFS_DATA_W-1];
    if (top == '0 || top == '1) begin
      return v[LFS_DATA_W-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(LFS_DATA_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(LFS_DATA_W - 1){1'b1}}};
    end
  endfunction

  logic en;
  logic accept;

  logic [FCW-1:0] fill_count;
  logic [FCW-1:0] fill_count_next;
  logic [FCW-1:0] fc_base;

  lfs_ctl_t  in_ctl;
  lfs_ctl_t  l1_ctl;
  lfs_taps_t l1_taps;
  lfs_ctl_t  d_ctl;
  logic signed [SW-1:0] d_s1;
  logic signed [SW-1:0] d_s2;
  lfs_ctl_t  e_ctl;
  logic signed [LFS_DATA_W-1:0] e_lap;
  lfs_ctl_t  l2_ctl;
  lfs_taps_t l2_taps;
  lfs_ctl_t  f_ctl;
  lfs_out_t  f_flux;

  logic     push;
  logic     skid_valid;
  lfs_out_t skid_data;

  // Pipeline moves only while the skid entry is free.
  assign en           = !skid_valid;
  assign sample_ready = en;
  assign accept       = sample_valid && sample_ready;

  always_comb begin
    fc_base         = sample_data.frame_start ? '0 : fill_count;
    fill_count_next = (fc_base < FCW'(WIN_DEPTH)) ? fc_base + FCW'(1) : fc_base;
    in_ctl.valid    = accept;
    in_ctl.emit     = accept && (fill_count_next == FCW'(WIN_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // Sample line: taps around the point R words behind the newest sample.
  lfs_line_buffer #(
    .ROW_LENGTH(ROW_LENGTH)
  ) u_sample_line (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (in_ctl),
    .in_data  (sample_data.sample),
    .out_ctl  (l1_ctl),
    .out_taps (l1_taps)
  );

  // Laplacian in two add stages, then saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
      e_ctl <= '0;
      f_ctl <= '0;
    end else if (en) begin
      d_ctl <= l1_ctl;
      e_ctl <= d_ctl;
      f_ctl <= l2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s1  <= (ext(l1_taps.age_r) <<< 2) - ext(l1_taps.age_rm1) - ext(l1_taps.age_rp1);
      d_s2  <= ext(l1_taps.age0) + ext(l1_taps.age_2r);
      e_lap <= sat(d_s1 - d_s2);
    end
  end

  // Laplacian line: south, east, centre, west and north taps.
  lfs_line_buffer #(
    .ROW_LENGTH(ROW_LENGTH)
  ) u_lap_line (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (e_ctl),
    .in_data  (e_lap),
    .out_ctl  (l2_ctl),
    .out_taps (l2_taps)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      f_flux.flux_west  <= l2_taps.age_r   - l2_taps.age_rp1;
      f_flux.flux_east  <= l2_taps.age_rm1 - l2_taps.age_r;
      f_flux.flux_north <= l2_taps.age_r   - l2_taps.age_2r;
      f_flux.flux_south <= l2_taps.age0    - l2_taps.age_r;
    end
  end

  // Output register plus one skid entry.
  assign push = en && f_ctl.valid && f_ctl.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= skid_valid || push;
      skid_valid   <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result_data <= skid_valid ? skid_data : f_flux;
    end else if (push) begin
      skid_data <= f_flux;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry full while output register empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FCW'(WIN_DEPTH))
    else $error("fill count beyond window depth");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && sample_data.frame_start |=> fill_count == FCW'(1))
    else $error("frame start did not restart fill count");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (!e_ctl.emit || e_ctl.valid) && (!f_ctl.emit || f_ctl.valid))
    else $error("result flag on an empty pipeline slot");
`endif

endmodule

`default_nettype wire

/* bench/laplacian_flux_stencil_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for laplacian_flux_stencil_unit: streams of grid samples with
// random idling, a flux predictor and an in-order scoreboard of flux words.
// Depends on lfs_pkg and the unit's RTL.
module laplacian_flux_stencil_unit_tb;
  import lfs_pkg::*;

  localparam int ROW            = LFS_ROW_LENGTH;
  localparam int WIN            = 4 * ROW + 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int PRINT_LIMIT    = 40;

  localparam logic signed [31:0] S_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN   = 32'sh80000000;
  localparam longint             LAP_MAX = 64'sd2147483647;
  localparam longint             LAP_MIN = -64'sd2147483648;

  typedef enum int {
    MODE_SMALL,
    MODE_FULL,
    MODE_EXTREME
  } value_mode_e;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     sample_valid = 1'b0;
  logic     sample_ready;
  lfs_in_t  sample_data = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  lfs_out_t result_data;

  // predictor state: newest sample first, at most one window deep
  logic signed [31:0] grid_hist[$];
  int unsigned        frame_fill = 0;
  lfs_out_t           flux_expected[$];
  lfs_out_t           flux_want;

  int          mismatch_count = 0;
  int          results_seen = 0;
  int          stuck_cycles = 0;
  int          ready_hold = 0;
  bit          idle_on = 1'b0;
  int          run_left = 0;
  value_mode_e run_mode = MODE_SMALL;

  always #1 clk = ~clk;

  laplacian_flux_stencil_unit #(
    .ROW_LENGTH(ROW)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample_data (sample_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic longint tap(input int unsigned age);
    return longint'(grid_hist[age]);
  endfunction

  function automatic logic signed [31:0] lap_sat(input int unsigned age);
    longint s;
    s = 4 * tap(age) - tap(age + 1) - tap(age - 1) - tap(age + ROW) - tap(age - ROW);
    if (s > LAP_MAX) s = LAP_MAX;
    else if (s < LAP_MIN) s = LAP_MIN;
    return s[31:0];
  endfunction

  function automatic void predict_flux(input lfs_in_t w);
    logic signed [31:0] lc, lw, le, ln, ls;
    lfs_out_t f;
    if (w.frame_start) frame_fill = 0;
    grid_hist.push_front(w.sample);
    if (grid_hist.size() > WIN) void'(grid_hist.pop_back());
    if (frame_fill < WIN) frame_fill++;
    if (frame_fill == WIN) begin
      // centre sits two rows behind the newest sample
      lc = lap_sat(2 * ROW);
      lw = lap_sat(2 * ROW + 1);
      le = lap_sat(2 * ROW - 1);
      ln = lap_sat(3 * ROW);
      ls = lap_sat(ROW);
      f.flux_west  = lc - lw;
      f.flux_east  = le - lc;
      f.flux_north = lc - ln;
      f.flux_south = ls - lc;
      flux_expected.push_back(f);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    // keep the log short; every mismatch is still counted
    if (mismatch_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) predict_flux(sample_data);
      if (result_valid && result_ready) begin
        if (flux_expected.size() == 0) begin
          report_mismatch($sformatf("result %0d with no word expected", results_seen));
        end else begin
          flux_want = flux_expected.pop_front();
          check_field("flux_west", result_data.flux_west, flux_want.flux_west);
          check_field("flux_east", result_data.flux_east, flux_want.flux_east);
          check_field("flux_north", result_data.flux_north, flux_want.flux_north);
          check_field("flux_south", result_data.flux_south, flux_want.flux_south);
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("laplacian_flux_stencil_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- idling

  function automatic int pick_idle();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      result_ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      result_ready <= 1'b1;
      ready_hold   <= pick_idle();
    end
  end

  // ---------------------------------------------------------------- stimulus

  // values come in runs of one kind so that both clipped and exact Laplacians occur
  function automatic logic signed [31:0] next_value();
    int v;
    if (run_left == 0) begin
      run_left = $urandom_range(1, 300);
      v = $urandom_range(0, 3);
      run_mode = (v < 2) ? MODE_SMALL : (v == 2) ? MODE_FULL : MODE_EXTREME;
    end
    run_left--;
    case (run_mode)
      MODE_FULL: begin
        return $urandom;
      end
      MODE_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: begin
        v = $urandom_range(0, 2000);
        return v - 1000;
      end
    endcase
  endfunction

  // returns at the accepting edge with valid still high
  task automatic send_word(input logic signed [31:0] value, input logic start);
    lfs_in_t w;
    int gap;
    w.sample      = value;
    w.frame_start = start;
    gap = pick_idle();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= w;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic stream_words(input int count, input logic marked);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_word(next_value(), (i == 0) ? marked : 1'b0);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (flux_expected.size() != 0) @(posedge clk);
  endtask

  // field extremes while the window fills; a frame mark mid-fill restarts the count
  task automatic test_fill_extremes();
    idle_on = 1'b0;
    send_word(S_MAX, 1'b0);
    send_word(S_MIN, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sh55555555, 1'b0);
    send_word(32'shaaaaaaaa, 1'b0);
    send_word(S_MAX, 1'b1);
    send_word(S_MIN, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word(S_MIN, 1'b1);
    send_word(S_MIN, 1'b0);
    send_word(32'sh0000ffff, 1'b0);
    send_word(32'shffff0000, 1'b0);
    send_word(-32'sd2, 1'b1);
    send_word(32'sd2, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word(32'sd0, 1'b1);
    send_word(S_MIN, 1'b0);
    send_word(S_MAX, 1'b0);
  endtask

  // one full frame: fill, then a run of results with clipping and wrap-around
  task automatic test_full_frame();
    stream_words(WIN + 119, 1'b1);
    // a further stretch; stream_words draws the idling switch anew at its first word
    idle_on = 1'b0;
    stream_words(60, 1'b0);
    idle_on = 1'b1;
  endtask

  // sender holds off until every pending flux word has come back
  task automatic test_drain_pause();
    idle_on = 1'b1;
    stream_words(30, 1'b0);
    sample_valid <= 1'b0;
    wait_drained();
    stream_words(30, 1'b0);
  endtask

  // frame mark with a full window stops results, another one mid-fill restarts the count
  task automatic test_restart();
    stream_words(60, 1'b1);
    stream_words(150, 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_extremes();
    test_full_frame();
    test_drain_pause();
    test_restart();
    sample_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (flux_expected.size() != 0)
      report_mismatch($sformatf("%0d flux words never arrived", flux_expected.size()));
    if (mismatch_count == 0) begin
      $display("laplacian_flux_stencil_unit: match");
    end else begin
      $display("laplacian_flux_stencil_unit: mismatch");
    end
    $finish;
  end

endmodule
